FILE: rtl/dcd_pkg.sv
// ----------------------------------------------------------------------------
// dcd_pkg
// shared constants, types and command codes of the directed cycle detector
// ----------------------------------------------------------------------------
package dcd_pkg;

   localparam int MAX_NODES   = 64;
   localparam int NODE_W      = $clog2(MAX_NODES);
   localparam int COUNT_W     = NODE_W + 1;
   localparam int CMD_W       = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   typedef logic [NODE_W-1:0]    node_type;
   typedef logic [COUNT_W-1:0]   count_type;
   typedef logic [MAX_NODES-1:0] row_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD_EDGE = 2'd0,
      CMD_CHECK    = 2'd1,
      CMD_CLEAR    = 2'd2
   } command_type;

   // register index as seen on the csr port (byte address / 4)
   localparam logic [CSR_ADDR_W-3:0] CSR_NODE_COUNT = '0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_WR,
      ST_START,
      ST_EXPLORE,
      ST_POP_WAIT,
      ST_DONE
   } state_type;

   // adjacency memory access
   typedef struct packed {
      node_type rd_addr;
      logic     wr_en;
      node_type wr_addr;
      row_type  wr_data;
      logic     clear;
   } adj_req_type;

   // walk stack access
   typedef struct packed {
      logic     wr_en;
      node_type wr_addr;
      node_type wr_data;
      node_type rd_addr;
   } stk_req_type;

endpackage

FILE: rtl/dcd_adj_mem.sv
// ----------------------------------------------------------------------------
// dcd_adj_mem
// adjacency bit matrix, one row per source node, with per-row valid bits
// ----------------------------------------------------------------------------
module dcd_adj_mem (
   input  logic                clock,
   input  logic                reset,
   input  dcd_pkg::adj_req_type req,
   output dcd_pkg::row_type    rd_row
);
   import dcd_pkg::*;

   row_type                 mem_ff [MAX_NODES];
   logic [MAX_NODES-1:0]    row_valid_ff;
   row_type                 rd_data_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem_ff[req.wr_addr] <= req.wr_data;
      end
      rd_data_ff <= mem_ff[req.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff <= row_valid_ff[req.rd_addr];
         if (req.clear) begin
            row_valid_ff <= '0;
         end else if (req.wr_en) begin
            row_valid_ff[req.wr_addr] <= 1'b1;
         end
      end
   end

   // a row never written since reset or clear reads as empty
   assign rd_row = rd_valid_ff ? rd_data_ff : '0;

endmodule

FILE: rtl/dcd_stack_mem.sv
// ----------------------------------------------------------------------------
// dcd_stack_mem
// node stack of the depth-first walk, registered read
// ----------------------------------------------------------------------------
module dcd_stack_mem (
   input  logic                 clock,
   input  dcd_pkg::stk_req_type req,
   output dcd_pkg::node_type    rd_node
);
   import dcd_pkg::*;

   node_type mem_ff [MAX_NODES];
   node_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem_ff[req.wr_addr] <= req.wr_data;
      end
      rd_data_ff <= mem_ff[req.rd_addr];
   end

   assign rd_node = rd_data_ff;

endmodule

FILE: rtl/dcd_pick.sv
// ----------------------------------------------------------------------------
// dcd_pick
// lowest set bit finder for the unvisited neighbor set
// ----------------------------------------------------------------------------
module dcd_pick (
   input  dcd_pkg::row_type  fresh,
   output logic              any,
   output dcd_pkg::node_type index
);
   import dcd_pkg::*;

   row_type  isolated;
   node_type idx;

   // two's complement trick keeps only the lowest set bit
   assign isolated = fresh & (~fresh + row_type'(1));

   always_comb begin
      idx = '0;
      for (int i = 0; i < MAX_NODES; i++) begin
         if (isolated[i]) begin
            idx = idx | node_type'(i);
         end
      end
   end

   assign any   = |fresh;
   assign index = idx;

endmodule

FILE: rtl/directed_cycle_detector.sv
// ----------------------------------------------------------------------------
// directed_cycle_detector
// edge-loaded directed graph with a depth-first cycle check
// ----------------------------------------------------------------------------
// Edges are written one transaction at a time into a 64 x 64 adjacency bit
// matrix (row u, bit v means u -> v); edges naming a node at or above
// node_count are dropped. A check transaction walks the graph depth first
// from every unvisited node in ascending order and returns one result
// transaction, cycle_found, which is 1 as soon as an edge from the node on top
// of the stack reaches a node on the current path (self-loops count). A clear
// transaction empties the matrix. Add and clear give no result. An add reads
// the row, then writes it back with the new bit set. A check scans the start
// nodes, pushes and pops nodes of the walk and hands over the result. The
// single read port of the adjacency memory delivers one row per search step,
// and each pop reads the new top from the stack memory.
// req_stall is high while a transaction is being worked on; a finished result
// waits in the output register, and a following check only stalls at its very
// end if that result has not been taken yet.
// ----------------------------------------------------------------------------
module directed_cycle_detector (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [dcd_pkg::CMD_W-1:0]         req_command,
   input  dcd_pkg::node_type                 req_from_node,
   input  dcd_pkg::node_type                 req_to_node,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_cycle_found,
   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [dcd_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [dcd_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [dcd_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import dcd_pkg::*;

   // sequencer state
   state_type   state_ff, state_in;
   node_type    from_ff, from_in;
   node_type    to_ff, to_in;
   count_type   start_ff, start_in;
   count_type   depth_ff, depth_in;
   node_type    top_ff, top_in;
   row_type     visited_ff, visited_in;
   row_type     path_ff, path_in;
   logic        found_ff, found_in;

   // configuration and result registers
   count_type   node_count_ff;
   logic        rsp_valid_ff;
   logic        rsp_found_ff;

   // memory and pick unit hookup
   adj_req_type adj_req;
   row_type     adj_row;
   stk_req_type stk_req;
   node_type    stk_node;
   logic        pick_any;
   node_type    pick_index;

   // derived values
   count_type   n_eff;
   row_type     live;
   row_type     nbrs;
   row_type     fresh;
   logic        hit;
   logic        push_ok;
   logic        req_take;
   logic        load_rsp;
   logic        csr_write;
   count_type   depth_less2;

   // ---------------------------------------------------------------- csr port
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= count_type'(MAX_NODES);
      end else if (csr_write && paddr[CSR_ADDR_W-1:2] == CSR_NODE_COUNT) begin
         node_count_ff <= pwdata[COUNT_W-1:0];
      end
   end

   assign prdata = (paddr[CSR_ADDR_W-1:2] == CSR_NODE_COUNT) ?
                   CSR_DATA_W'(node_count_ff) : '0;

   // effective node count and mask of nodes in use
   assign n_eff = (node_count_ff > count_type'(MAX_NODES)) ?
                  count_type'(MAX_NODES) : node_count_ff;
   assign live  = (n_eff >= count_type'(MAX_NODES)) ? '1 :
                  ((row_type'(1) << n_eff[NODE_W-1:0]) - row_type'(1));

   // ------------------------------------------------------------ submodules
   dcd_adj_mem u_adj_mem (
      .clock  (clock),
      .reset  (reset),
      .req    (adj_req),
      .rd_row (adj_row)
   );

   dcd_stack_mem u_stack_mem (
      .clock   (clock),
      .req     (stk_req),
      .rd_node (stk_node)
   );

   // neighbors of the top node: cycle test and next unvisited pick
   assign nbrs  = adj_row & live;
   assign hit   = |(nbrs & path_ff);
   assign fresh = nbrs & ~visited_ff;

   dcd_pick u_pick (
      .fresh (fresh),
      .any   (pick_any),
      .index (pick_index)
   );

   // ------------------------------------------------------------- sequencer
   assign req_stall   = (state_ff != ST_IDLE);
   assign req_take    = req_valid & ~req_stall;
   assign push_ok     = (depth_ff != count_type'(MAX_NODES));
   assign depth_less2 = depth_ff - count_type'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         start_ff   <= '0;
         depth_ff   <= '0;
         visited_ff <= '0;
         path_ff    <= '0;
         found_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         start_ff   <= start_in;
         depth_ff   <= depth_in;
         visited_ff <= visited_in;
         path_ff    <= path_in;
         found_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      from_ff <= from_in;
      to_ff   <= to_in;
      top_ff  <= top_in;
   end

   always_comb begin
      state_in   = state_ff;
      from_in    = from_ff;
      to_in      = to_ff;
      start_in   = start_ff;
      depth_in   = depth_ff;
      top_in     = top_ff;
      visited_in = visited_ff;
      path_in    = path_ff;
      found_in   = found_ff;
      load_rsp   = 1'b0;

      adj_req         = '0;
      adj_req.rd_addr = top_ff;
      stk_req         = '0;
      stk_req.rd_addr = depth_less2[NODE_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            adj_req.rd_addr = req_from_node;
            from_in         = req_from_node;
            to_in           = req_to_node;
            if (req_take) begin
               unique case (req_command)
                  CMD_ADD_EDGE: begin
                     // row read now, merged and written back next cycle
                     if (count_type'(req_from_node) < n_eff &&
                         count_type'(req_to_node) < n_eff) begin
                        state_in = ST_ADD_WR;
                     end
                  end
                  CMD_CHECK: begin
                     visited_in = '0;
                     path_in    = '0;
                     depth_in   = '0;
                     start_in   = '0;
                     state_in   = ST_START;
                  end
                  CMD_CLEAR: begin
                     adj_req.clear = 1'b1;
                  end
                  default: begin
                     // unused command, dropped
                  end
               endcase
            end
         end

         ST_ADD_WR: begin
            adj_req.wr_en   = 1'b1;
            adj_req.wr_addr = from_ff;
            adj_req.wr_data = adj_row | (row_type'(1) << to_ff);
            state_in        = ST_IDLE;
         end

         ST_START: begin
            adj_req.rd_addr = start_ff[NODE_W-1:0];
            if (start_ff >= n_eff) begin
               // every start node done without a back edge
               found_in = 1'b0;
               state_in = ST_DONE;
            end else if (visited_ff[start_ff[NODE_W-1:0]]) begin
               start_in = start_ff + count_type'(1);
            end else begin
               visited_in[start_ff[NODE_W-1:0]] = 1'b1;
               path_in[start_ff[NODE_W-1:0]]    = 1'b1;
               stk_req.wr_en   = 1'b1;
               stk_req.wr_addr = '0;
               stk_req.wr_data = start_ff[NODE_W-1:0];
               top_in          = start_ff[NODE_W-1:0];
               depth_in        = count_type'(1);
               state_in        = ST_EXPLORE;
            end
         end

         ST_EXPLORE: begin
            // adj_row holds the row of top_ff
            if (hit) begin
               found_in = 1'b1;
               state_in = ST_DONE;
            end else if (pick_any) begin
               visited_in[pick_index] = 1'b1;
               path_in[pick_index]    = 1'b1;
               if (push_ok) begin
                  stk_req.wr_en   = 1'b1;
                  stk_req.wr_addr = depth_ff[NODE_W-1:0];
                  stk_req.wr_data = pick_index;
                  depth_in        = depth_ff + count_type'(1);
                  top_in          = pick_index;
                  adj_req.rd_addr = pick_index;
               end
            end else begin
               // dead end: leave the path and pop
               path_in[top_ff] = 1'b0;
               depth_in        = depth_ff - count_type'(1);
               if (depth_ff == count_type'(1)) begin
                  start_in = start_ff + count_type'(1);
                  state_in = ST_START;
               end else begin
                  state_in = ST_POP_WAIT;
               end
            end
         end

         ST_POP_WAIT: begin
            // stack read of the new top has landed
            top_in          = stk_node;
            adj_req.rd_addr = stk_node;
            state_in        = ST_EXPLORE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_found_ff <= found_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cycle_found = rsp_found_ff;

   // ------------------------------------------------------------ assertions
   // stack never grows past MAX_NODES
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= count_type'(MAX_NODES))
      else $error("walk stack depth out of range");

   // every node on the path has been visited
   a_path_visited: assert property (@(posedge clock) disable iff (reset)
      (path_ff & ~visited_ff) == '0)
      else $error("path mark without visited mark");

   // while exploring the stack is not empty and its top is on the path
   a_top_on_path: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXPLORE |-> (depth_ff != '0) && path_ff[top_ff])
      else $error("explore with empty stack or top off the path");

   // a result is only loaded from the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result transaction outside the done state");

endmodule
